// ===== rtl/stq_pkg.sv =====
package stq_pkg;

	localparam int HANDLE_W = 10;
	localparam int TIME_W   = 32;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_ADJUST = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_STATUS  = 2'd0,
		KIND_EXPIRED = 2'd1,
		KIND_NONE    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_DUPLICATE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOOK,
		OP_INSERT,
		OP_REMOVE,
		OP_POP
	} cell_op_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   expire_time;
		logic [TIME_W-1:0]   current_time;
	} req_t;

	typedef struct packed {
		kind_t               result_kind;
		logic [HANDLE_W-1:0] out_handle;
		status_t             status;
		logic                last;
	} res_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t            op;
		logic [HANDLE_W-1:0] handle;
	} cell_ctrl_t;

endpackage

// ===== rtl/sorted_timer_queue.sv =====
// channel   direction  handshake                   payload
// command   in         start high while busy low   req (stq_pkg::req_t)
// result    out        res_valid, one cycle        res (stq_pkg::res_t)
//
// add and delete pass through S_LOOK and S_EXEC before the result, adjust also through S_INSERT when found, and a tick
// stays in S_TICK for n results (at least one); busy is low again in the cycle the final result shows.
// the handle reduction and the registered match lookup in the cell chain come ahead of the shift;
// an adjust shifts the chain twice, a tick pops one cell a cycle.
// arst_n clears the state and every cell's valid bit: the queue comes up empty.
// results are strobed for one cycle and cannot be stalled.
module sorted_timer_queue #(
	parameter int DEPTH        = 32,
	parameter int HANDLE_COUNT = 1024,
	parameter int TIME_WIDTH   = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  stq_pkg::req_t req,
	output logic          res_valid,
	output stq_pkg::res_t res
);
	import stq_pkg::*;

	localparam int TW = (TIME_WIDTH < TIME_W) ? TIME_WIDTH : TIME_W;
	localparam int RecipShift = 20;
	localparam logic [20:0] Recip = 21'((1 << RecipShift) / HANDLE_COUNT);
	localparam logic [16:0] Hc = 17'(HANDLE_COUNT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_EXEC,
		S_INSERT,
		S_TICK
	} state_t;

	state_t              state_q;
	cmd_t                cmd_q;
	logic [HANDLE_W-1:0] hraw_q;
	logic [HANDLE_W-1:0] quot_q;
	logic [HANDLE_W-1:0] h_q;
	logic [TW-1:0]       exp_q;
	logic [TW-1:0]       now_q;
	res_t                res_q;
	logic                res_valid_q;

	logic [30:0]         prod;
	logic [26:0]         qhc;
	logic [HANDLE_W-1:0] rem0;
	logic [HANDLE_W-1:0] hred;
	logic                accept;
	cell_ctrl_t          ctrl;
	logic [TW-1:0]       key;

	logic [DEPTH-1:0]    c_valid;
	logic [DEPTH-1:0]    c_le;
	logic [DEPTH-1:0]    c_gone;
	logic [DEPTH-1:0]    c_match;
	logic [TW-1:0]       c_exp [DEPTH];
	logic [HANDLE_W-1:0] c_hdl [DEPTH];

	logic                full;
	logic                any_match;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// handle modulo HANDLE_COUNT: reciprocal estimate, then one correction step
	assign prod = 31'(req.handle) * 31'(Recip);
	assign qhc  = 27'(quot_q) * 27'(Hc);
	assign rem0 = hraw_q - qhc[HANDLE_W-1:0];
	assign hred = (17'(rem0) >= Hc) ? (rem0 - Hc[HANDLE_W-1:0]) : rem0;

	assign full      = c_valid[DEPTH-1];
	assign any_match = |c_match;
	assign key       = (state_q == S_TICK) ? now_q : exp_q;

	always_comb begin
		ctrl.handle = (state_q == S_LOOK) ? hred : h_q;
		ctrl.op     = OP_HOLD;
		case (state_q)
			S_LOOK: ctrl.op = OP_LOOK;
			S_EXEC: begin
				case (cmd_q)
					CMD_ADD: begin
						if (!any_match && !full) ctrl.op = OP_INSERT;
					end
					CMD_ADJUST, CMD_DELETE: begin
						if (any_match) ctrl.op = OP_REMOVE;
					end
					default: ;
				endcase
			end
			S_INSERT: ctrl.op = OP_INSERT;
			S_TICK: begin
				if (c_le[0]) ctrl.op = OP_POP;
			end
			default: ;
		endcase
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                p_valid;
		logic [TW-1:0]       p_exp;
		logic [HANDLE_W-1:0] p_hdl;
		logic                p_le;
		logic                p_gone;
		logic                n_valid;
		logic [TW-1:0]       n_exp;
		logic [HANDLE_W-1:0] n_hdl;

		if (i == 0) begin : g_head
			assign p_valid = 1'b0;
			assign p_exp   = '0;
			assign p_hdl   = '0;
			assign p_le    = 1'b1;
			assign p_gone  = 1'b0;
		end else begin : g_body
			assign p_valid = c_valid[i-1];
			assign p_exp   = c_exp[i-1];
			assign p_hdl   = c_hdl[i-1];
			assign p_le    = c_le[i-1];
			assign p_gone  = c_gone[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_exp   = '0;
			assign n_hdl   = '0;
		end else begin : g_inner
			assign n_valid = c_valid[i+1];
			assign n_exp   = c_exp[i+1];
			assign n_hdl   = c_hdl[i+1];
		end

		stq_cell #(
			.TW(TW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.key      (key),
			.l_valid  (p_valid),
			.l_expiry (p_exp),
			.l_handle (p_hdl),
			.l_le     (p_le),
			.l_gone   (p_gone),
			.r_valid  (n_valid),
			.r_expiry (n_exp),
			.r_handle (n_hdl),
			.valid    (c_valid[i]),
			.expiry   (c_exp[i]),
			.handle   (c_hdl[i]),
			.le       (c_le[i]),
			.gone     (c_gone[i]),
			.match    (c_match[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (req.cmd == CMD_TICK) ? S_TICK : S_LOOK;
					end
				end
				S_LOOK: state_q <= S_EXEC;
				S_EXEC: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
					if (cmd_q == CMD_ADJUST && any_match) begin
						res_valid_q <= 1'b0;
						state_q     <= S_INSERT;
					end
				end
				S_INSERT: begin
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_TICK: begin
					res_valid_q <= 1'b1;
					if (!c_le[0] || !c_le[1]) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// transaction payload and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			hraw_q <= req.handle;
			quot_q <= prod[RecipShift +: HANDLE_W];
			exp_q  <= req.expire_time[TW-1:0];
			now_q  <= req.current_time[TW-1:0];
		end
		if (state_q == S_LOOK) begin
			h_q <= hred;
		end
		case (state_q)
			S_EXEC: begin
				res_q.result_kind <= KIND_STATUS;
				res_q.out_handle  <= h_q;
				res_q.last        <= 1'b1;
				if (cmd_q == CMD_ADD) begin
					if (any_match) begin
						res_q.status <= ST_DUPLICATE;
					end else if (full) begin
						res_q.status <= ST_FULL;
					end else begin
						res_q.status <= ST_OK;
					end
				end else begin
					res_q.status <= any_match ? ST_OK : ST_NOT_FOUND;
				end
			end
			S_INSERT: begin
				res_q.result_kind <= KIND_STATUS;
				res_q.out_handle  <= h_q;
				res_q.status      <= ST_OK;
				res_q.last        <= 1'b1;
			end
			S_TICK: begin
				res_q.status <= ST_OK;
				if (c_le[0]) begin
					res_q.result_kind <= KIND_EXPIRED;
					res_q.out_handle  <= c_hdl[0];
					res_q.last        <= !c_le[1];
				end else begin
					res_q.result_kind <= KIND_NONE;
					res_q.out_handle  <= '0;
					res_q.last        <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTH
	// occupied cells always form an unbroken run from the head
	a_valid_run: assert property (@(posedge clk) disable iff (!arst_n)
		((c_valid >> 1) & ~c_valid) == '0)
		else $error("gap in occupied cells");

	// handles are unique, so a lookup hits at most one cell
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(c_match))
		else $error("handle found in more than one cell");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.result_kind != KIND_EXPIRED) |-> res.last)
		else $error("single result without last");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");

	a_pop_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK && c_le[0] && c_le[1]) |=> (state_q == S_TICK))
		else $error("tick stopped with expired entries left");
`endif

endmodule

// ===== rtl/stq_cell.sv =====
module stq_cell #(
	parameter int TW = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stq_pkg::cell_ctrl_t        ctrl,
	input  logic [TW-1:0]              key,
	input  logic                       l_valid,
	input  logic [TW-1:0]              l_expiry,
	input  logic [stq_pkg::HANDLE_W-1:0] l_handle,
	input  logic                       l_le,
	input  logic                       l_gone,
	input  logic                       r_valid,
	input  logic [TW-1:0]              r_expiry,
	input  logic [stq_pkg::HANDLE_W-1:0] r_handle,
	output logic                       valid,
	output logic [TW-1:0]              expiry,
	output logic [stq_pkg::HANDLE_W-1:0] handle,
	output logic                       le,
	output logic                       gone,
	output logic                       match
);
	import stq_pkg::*;

	logic                valid_q;
	logic                match_q;
	logic [TW-1:0]       expiry_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                n_valid;
	logic [TW-1:0]       n_expiry;
	logic [HANDLE_W-1:0] n_handle;

	assign le     = valid_q && (expiry_q <= key);
	// set from the matching cell rightwards: those cells close the gap
	assign gone   = l_gone | match_q;
	assign valid  = valid_q;
	assign expiry = expiry_q;
	assign handle = handle_q;
	assign match  = match_q;

	always_comb begin
		n_valid  = valid_q;
		n_expiry = expiry_q;
		n_handle = handle_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (!le) begin
					if (l_le) begin
						n_valid  = 1'b1;
						n_expiry = key;
						n_handle = ctrl.handle;
					end else begin
						n_valid  = l_valid;
						n_expiry = l_expiry;
						n_handle = l_handle;
					end
				end
			end
			OP_REMOVE: begin
				if (gone) begin
					n_valid  = r_valid;
					n_expiry = r_expiry;
					n_handle = r_handle;
				end
			end
			OP_POP: begin
				n_valid  = r_valid;
				n_expiry = r_expiry;
				n_handle = r_handle;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			valid_q <= n_valid;
			if (ctrl.op == OP_LOOK) begin
				match_q <= valid_q && (handle_q == ctrl.handle);
			end
		end
	end

	always_ff @(posedge clk) begin
		expiry_q <= n_expiry;
		handle_q <= n_handle;
	end

endmodule
